>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared property forms for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is applied
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is applied
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/sss_pkg.sv
// ---------------------------------------------------------------------------
// sss_pkg
// shared sizes, command/status types and the decay table
// ---------------------------------------------------------------------------
package sss_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SUM_W      = 64 + 2 * IDX_W;
  localparam int DIV_W      = SUM_W + 16;
  localparam int SQ_W       = 66;
  localparam int RT_W       = SQ_W / 2;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int EXP_BITS   = 20;
  localparam int EXP_IDX_W  = $clog2(EXP_BITS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd2;

  typedef enum logic [4:0] {
    S_LOAD, S_START, S_RDI, S_LATI, S_RDJ, S_DIFF, S_MDT, S_MDX,
    S_MDY, S_MVV, S_SQD, S_WSQD, S_MDR, S_DVX, S_WDVX, S_SQG,
    S_WSQG, S_EXM, S_EXU, S_MGE, S_AS2, S_NN, S_N2, S_DV1,
    S_WDV1, S_DVA, S_WDVA, S_DVB, S_WDVB, S_SQV, S_WSQV, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_DT, MUL_DX, MUL_DY, MUL_VV, MUL_DR, MUL_EXP, MUL_GE, MUL_NN
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLR, OP_I, OP_J, OP_S1, OP_DD_LOAD, OP_DD_ADD, OP_VV,
    OP_DIST, OP_X, OP_G, OP_EXP, OP_S2, OP_N2, OP_Q1, OP_A
  } op_t;

  typedef enum logic [1:0] {SQ_DD, SQ_VV, SQ_VAR} sq_src_t;

  typedef enum logic [1:0] {DV_X, DV_S1, DV_A, DV_S2} dv_src_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     addr;
    mul_sel_t             mul_sel;
    op_t                  op;
    logic                 b_lat;
    logic                 res_lat;
    logic                 sqrt_start;
    sq_src_t              sq_src;
    logic                 div_start;
    dv_src_t              dv_src;
    logic [EXP_IDX_W-1:0] exp_bit;
    logic                 out_load;
    logic [CNT_W-1:0]     n;
    logic                 dropped;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } sts_t;

  // floor(exp(-2^(b-16)) * 2^32)
  function automatic logic [31:0] exp_coef(input logic [EXP_IDX_W-1:0] b);
    logic [31:0] c;
    case (b)
      5'd0:    c = 32'd4294901760;
      5'd1:    c = 32'd4294836225;
      5'd2:    c = 32'd4294705159;
      5'd3:    c = 32'd4294443039;
      5'd4:    c = 32'd4293918847;
      5'd5:    c = 32'd4292870655;
      5'd6:    c = 32'd4290775039;
      5'd7:    c = 32'd4286586874;
      5'd8:    c = 32'd4278222805;
      5'd9:    c = 32'd4261543595;
      5'd10:   c = 32'd4228379999;
      5'd11:   c = 32'd4162825044;
      5'd12:   c = 32'd4034748382;
      5'd13:   c = 32'd3790295335;
      5'd14:   c = 32'd3344923893;
      5'd15:   c = 32'd2605029347;
      5'd16:   c = 32'd1580030168;
      5'd17:   c = 32'd581260615;
      5'd18:   c = 32'd78665070;
      5'd19:   c = 32'd1440801;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

>>> sv/sss_div.sv
// ---------------------------------------------------------------------------
// sss_div
// restoring divider, one quotient bit per cycle, 32-bit divisor
// ---------------------------------------------------------------------------
module sss_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sss_pkg::DIV_W-1:0] dividend,
  input  logic [31:0]               divisor,
  output logic                      done,
  output logic [sss_pkg::DIV_W-1:0] quot
);
  import sss_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       dsr_r, dsr_nxt;
  logic [32:0]       rem_sh;
  logic              ge;

  assign rem_sh = {rem_r, dvd_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(rem_sh - {1'b0, dsr_r}) : rem_sh[31:0];
      dvd_nxt = {dvd_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

>>> sv/sss_sqrt.sv
// ---------------------------------------------------------------------------
// sss_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ---------------------------------------------------------------------------
module sss_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [sss_pkg::SQ_W-1:0] rad,
  output logic                     done,
  output logic [sss_pkg::RT_W-1:0] root
);
  import sss_pkg::*;

  localparam int STEP_W = $clog2(RT_W);
  localparam int REM_W  = RT_W + 3;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [SQ_W-1:0]   rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [RT_W-1:0]   root_r, root_nxt;
  logic [REM_W-1:0]  rem_sh, trial;
  logic              ge;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[SQ_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[SQ_W-3:0], 2'b00};
      rem_nxt  = ge ? rem_sh - trial : rem_sh;
      root_nxt = {root_r[RT_W-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(RT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> sv/sss_dpath.sv
// ---------------------------------------------------------------------------
// sss_dpath
// point stores, shared multiplier, sums, divider, square root, output regs
// ---------------------------------------------------------------------------
module sss_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sss_pkg::cmd_t                 cmd,
  output sss_pkg::sts_t                 sts,
  input  logic signed [31:0]            in_longitude,
  input  logic signed [31:0]            in_latitude,
  input  logic signed [31:0]            in_target_value,
  input  logic [31:0]                   in_variance,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_stratum_stdev,
  output logic [sss_pkg::CNT_W-1:0]     out_points_used,
  output logic                          out_overflow_flag
);
  import sss_pkg::*;

  localparam int TERM_W = 50;

  function automatic logic [31:0] absdiff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  // point stores
  logic [31:0] lon_mem [MAX_POINTS];
  logic [31:0] lat_mem [MAX_POINTS];
  logic [31:0] tgt_mem [MAX_POINTS];
  logic [31:0] var_mem [MAX_POINTS];
  logic [31:0] rd_lon_r, rd_lat_r, rd_tgt_r, rd_var_r;

  // config
  logic [31:0] fit_r, fit_nxt, rng_r, rng_nxt;
  logic [7:0]  decay_r, decay_nxt;
  logic [31:0] fit_eff, rng_eff;

  // pair work registers
  logic [31:0]          ilon_r, ilat_r, itgt_r, ivar_r;
  logic [31:0]          dt_r, dx_r, dy_r, jvar_r;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [SQ_W-1:0]      dd_r;
  logic [63:0]          vv_r;
  logic [SUM_W-1:0]     s1_r, s2_r;
  logic [RT_W-1:0]      dist_r, g_r;
  logic                 x_big_r;
  logic [EXP_BITS-1:0]  x_lo_r;
  logic [32:0]          eacc_r;
  logic [16:0]          e_val;
  logic [32:0]          vsum;
  logic [TERM_W-1:0]    term_nxt;
  logic [31:0]          n2_r;
  logic [DIV_W-1:0]     q1_r, a_r, b_r;
  logic [DIV_W:0]       var_sum;
  logic                 sat;
  logic [31:0]          res_r;

  // shared units
  logic [DIV_W-1:0] div_dvd, div_quot;
  logic [31:0]      div_dsr;
  logic             div_done;
  logic [SQ_W-1:0]  sq_rad;
  logic [RT_W-1:0]  sq_root;
  logic             sq_done;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_stdev_r;
  logic [CNT_W-1:0]  out_pts_r;
  logic              out_ovf_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      lon_mem[cmd.addr] <= in_longitude;
      lat_mem[cmd.addr] <= in_latitude;
      tgt_mem[cmd.addr] <= in_target_value;
      var_mem[cmd.addr] <= in_variance;
    end
    rd_lon_r <= lon_mem[cmd.addr];
    rd_lat_r <= lat_mem[cmd.addr];
    rd_tgt_r <= tgt_mem[cmd.addr];
    rd_var_r <= var_mem[cmd.addr];
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    fit_nxt   = fit_r;
    rng_nxt   = rng_r;
    decay_nxt = decay_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIT:   fit_nxt   = cfg_data;
        CFG_RANGE: rng_nxt   = cfg_data;
        CFG_DECAY: decay_nxt = cfg_data[7:0];
        default:   ;
      endcase
    end
  end

  assign fit_eff = (fit_r == '0) ? 32'd1 : fit_r;
  assign rng_eff = (rng_r == '0) ? 32'd1 : rng_r;

  // decay factor is zero once the exponent reaches 16.0
  assign e_val = x_big_r ? '0 : eacc_r[32:16];

  always_comb begin
    case (cmd.mul_sel)
      MUL_DT:  begin mul_a = MUL_W'(dt_r);    mul_b = MUL_W'(dt_r);   end
      MUL_DX:  begin mul_a = MUL_W'(dx_r);    mul_b = MUL_W'(dx_r);   end
      MUL_DY:  begin mul_a = MUL_W'(dy_r);    mul_b = MUL_W'(dy_r);   end
      MUL_VV:  begin mul_a = MUL_W'(ivar_r);  mul_b = MUL_W'(jvar_r); end
      MUL_DR:  begin mul_a = MUL_W'(decay_r); mul_b = dist_r;         end
      MUL_EXP: begin mul_a = eacc_r;          mul_b = MUL_W'(exp_coef(cmd.exp_bit)); end
      MUL_GE:  begin mul_a = g_r;             mul_b = MUL_W'(e_val);  end
      MUL_NN:  begin mul_a = MUL_W'(cmd.n);   mul_b = MUL_W'(cmd.n);  end
      default: begin mul_a = '0;              mul_b = '0;             end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // pair term: ((vi+vj)<<16) - 2*g*e, never negative
  assign vsum     = {1'b0, ivar_r} + {1'b0, jvar_r};
  assign term_nxt = TERM_W'({vsum, 16'b0}) - TERM_W'({prod_r[48:0], 1'b0});

  always_comb begin
    case (cmd.dv_src)
      DV_X:    begin div_dvd = DIV_W'({prod_r[40:0], 16'b0});   div_dsr = rng_eff; end
      DV_S1:   begin div_dvd = DIV_W'(s1_r);                    div_dsr = n2_r;    end
      DV_A:    begin div_dvd = DIV_W'({q1_r[SUM_W-1:0], 16'b0}); div_dsr = fit_eff; end
      DV_S2:   begin div_dvd = DIV_W'(s2_r);                    div_dsr = n2_r;    end
      default: begin div_dvd = '0;                              div_dsr = 32'd1;   end
    endcase
  end

  assign var_sum = {1'b0, a_r} + {1'b0, b_r};
  assign sat     = |var_sum[DIV_W:64];

  always_comb begin
    case (cmd.sq_src)
      SQ_DD:   sq_rad = dd_r;
      SQ_VV:   sq_rad = SQ_W'(vv_r);
      SQ_VAR:  sq_rad = SQ_W'(var_sum[63:0]);
      default: sq_rad = '0;
    endcase
  end

  sss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_quot)
  );

  sss_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .rad   (sq_rad),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (cmd.op)
      OP_CLR: begin
        s1_r <= '0;
        s2_r <= '0;
      end
      OP_I: begin
        ilon_r <= rd_lon_r;
        ilat_r <= rd_lat_r;
        itgt_r <= rd_tgt_r;
        ivar_r <= rd_var_r;
      end
      OP_J: begin
        dt_r   <= absdiff(itgt_r, rd_tgt_r);
        dx_r   <= absdiff(ilon_r, rd_lon_r);
        dy_r   <= absdiff(ilat_r, rd_lat_r);
        jvar_r <= rd_var_r;
      end
      OP_S1:      s1_r <= s1_r + SUM_W'(prod_r);
      OP_DD_LOAD: dd_r <= prod_r;
      OP_DD_ADD:  dd_r <= dd_r + prod_r;
      OP_VV:      vv_r <= prod_r[63:0];
      OP_DIST:    dist_r <= sq_root;
      OP_X: begin
        x_big_r <= |div_quot[DIV_W-1:EXP_BITS];
        x_lo_r  <= div_quot[EXP_BITS-1:0];
      end
      OP_G: begin
        g_r    <= sq_root;
        eacc_r <= 33'h1_0000_0000;
      end
      OP_EXP: begin
        if (x_lo_r[cmd.exp_bit]) begin
          eacc_r <= prod_r[64:32];
        end
      end
      OP_S2: s2_r <= s2_r + SUM_W'(term_nxt);
      OP_N2: n2_r <= prod_r[31:0];
      OP_Q1: q1_r <= div_quot;
      OP_A:  a_r  <= div_quot;
      default: ;
    endcase
    if (cmd.b_lat) begin
      b_r <= div_quot;
    end
    if (cmd.res_lat) begin
      res_r <= sq_root[31:0];
    end
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fit_r       <= 32'h0001_0000;
      rng_r       <= 32'h0001_0000;
      decay_r     <= 8'd1;
    end else begin
      out_valid_r <= out_valid_nxt;
      fit_r       <= fit_nxt;
      rng_r       <= rng_nxt;
      decay_r     <= decay_nxt;
    end
    if (cmd.out_load) begin
      out_stdev_r <= sat ? '1 : res_r;
      out_pts_r   <= cmd.n;
      out_ovf_r   <= sat | cmd.dropped;
    end
  end

  assign sts.sqrt_done = sq_done;
  assign sts.div_done  = div_done;
  assign sts.out_free  = ~out_valid_r | ~out_stall;

  assign out_valid         = out_valid_r;
  assign out_stratum_stdev = out_stdev_r;
  assign out_points_used   = out_pts_r;
  assign out_overflow_flag = out_ovf_r;

endmodule

>>> sv/sss_ctrl.sv
// ---------------------------------------------------------------------------
// sss_ctrl
// sequencer: point loading, pair loop, final division and root
// ---------------------------------------------------------------------------
module sss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_point,
  output logic          in_stall,
  input  sss_pkg::sts_t sts,
  output sss_pkg::cmd_t cmd
);
  import sss_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 drop_r, drop_nxt;
  logic [IDX_W-1:0]     i_r, i_nxt, j_r, j_nxt;
  logic [EXP_IDX_W-1:0] b_r, b_nxt;
  logic                 in_acc, full, j_end, i_end;

  assign in_acc = in_valid & ~in_stall;
  assign full   = cnt_r == CNT_W'(MAX_POINTS);
  assign j_end  = j_r == IDX_W'(cnt_r - 1'b1);
  assign i_end  = i_r == IDX_W'(cnt_r - 2'd2);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  if (in_acc && in_last_point) state_nxt = S_START;
      S_START: state_nxt = (cnt_r >= CNT_W'(2)) ? S_RDI : S_NN;
      S_RDI:   state_nxt = S_LATI;
      S_LATI:  state_nxt = S_RDJ;
      S_RDJ:   state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MDT;
      S_MDT:   state_nxt = S_MDX;
      S_MDX:   state_nxt = S_MDY;
      S_MDY:   state_nxt = S_MVV;
      S_MVV:   state_nxt = S_SQD;
      S_SQD:   state_nxt = S_WSQD;
      S_WSQD:  if (sts.sqrt_done) state_nxt = S_MDR;
      S_MDR:   state_nxt = S_DVX;
      S_DVX:   state_nxt = S_WDVX;
      S_WDVX:  if (sts.div_done) state_nxt = S_SQG;
      S_SQG:   state_nxt = S_WSQG;
      S_WSQG:  if (sts.sqrt_done) state_nxt = S_EXM;
      S_EXM:   state_nxt = S_EXU;
      S_EXU:   state_nxt = (b_r == EXP_IDX_W'(EXP_BITS - 1)) ? S_MGE : S_EXM;
      S_MGE:   state_nxt = S_AS2;
      S_AS2: begin
        if (!j_end)     state_nxt = S_RDJ;
        else if (i_end) state_nxt = S_NN;
        else            state_nxt = S_RDI;
      end
      S_NN:    state_nxt = S_N2;
      S_N2:    state_nxt = S_DV1;
      S_DV1:   state_nxt = S_WDV1;
      S_WDV1:  if (sts.div_done) state_nxt = S_DVA;
      S_DVA:   state_nxt = S_WDVA;
      S_WDVA:  if (sts.div_done) state_nxt = S_DVB;
      S_DVB:   state_nxt = S_WDVB;
      S_WDVB:  if (sts.div_done) state_nxt = S_SQV;
      S_SQV:   state_nxt = S_WSQV;
      S_WSQV:  if (sts.sqrt_done) state_nxt = S_FIN;
      S_FIN:   if (sts.out_free) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  // loop counters
  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    b_nxt    = b_r;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (full) drop_nxt = 1'b1;
          else      cnt_nxt  = cnt_r + 1'b1;
        end
      end
      S_START: i_nxt = '0;
      S_LATI:  j_nxt = i_r + 1'b1;
      S_SQG:   b_nxt = '0;
      S_EXU:   b_nxt = b_r + 1'b1;
      S_AS2: begin
        if (!j_end) j_nxt = j_r + 1'b1;
        else        i_nxt = i_r + 1'b1;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cnt_nxt  = '0;
          drop_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_DT;
    cmd.op      = OP_NONE;
    cmd.sq_src  = SQ_DD;
    cmd.dv_src  = DV_X;
    cmd.exp_bit = b_r;
    cmd.n       = cnt_r;
    cmd.dropped = drop_r;
    in_stall    = 1'b1;
    case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        cmd.we   = in_acc & ~full;
        cmd.addr = cnt_r[IDX_W-1:0];
      end
      S_START: cmd.op = OP_CLR;
      S_RDI:   cmd.addr = i_r;
      S_LATI:  cmd.op = OP_I;
      S_RDJ:   cmd.addr = j_r;
      S_DIFF:  cmd.op = OP_J;
      S_MDT:   cmd.mul_sel = MUL_DT;
      S_MDX: begin
        cmd.mul_sel = MUL_DX;
        cmd.op      = OP_S1;
      end
      S_MDY: begin
        cmd.mul_sel = MUL_DY;
        cmd.op      = OP_DD_LOAD;
      end
      S_MVV: begin
        cmd.mul_sel = MUL_VV;
        cmd.op      = OP_DD_ADD;
      end
      S_SQD: begin
        cmd.op         = OP_VV;
        cmd.sqrt_start = 1'b1;
        cmd.sq_src     = SQ_DD;
      end
      S_WSQD:  if (sts.sqrt_done) cmd.op = OP_DIST;
      S_MDR:   cmd.mul_sel = MUL_DR;
      S_DVX: begin
        cmd.div_start = 1'b1;
        cmd.dv_src    = DV_X;
      end
      S_WDVX:  if (sts.div_done) cmd.op = OP_X;
      S_SQG: begin
        cmd.sqrt_start = 1'b1;
        cmd.sq_src     = SQ_VV;
      end
      S_WSQG:  if (sts.sqrt_done) cmd.op = OP_G;
      S_EXM:   cmd.mul_sel = MUL_EXP;
      S_EXU:   cmd.op = OP_EXP;
      S_MGE:   cmd.mul_sel = MUL_GE;
      S_AS2:   cmd.op = OP_S2;
      S_NN:    cmd.mul_sel = MUL_NN;
      S_N2:    cmd.op = OP_N2;
      S_DV1: begin
        cmd.div_start = 1'b1;
        cmd.dv_src    = DV_S1;
      end
      S_WDV1:  if (sts.div_done) cmd.op = OP_Q1;
      S_DVA: begin
        cmd.div_start = 1'b1;
        cmd.dv_src    = DV_A;
      end
      S_WDVA:  if (sts.div_done) cmd.op = OP_A;
      S_DVB: begin
        cmd.div_start = 1'b1;
        cmd.dv_src    = DV_S2;
      end
      S_WDVB:  cmd.b_lat = sts.div_done;
      S_SQV: begin
        cmd.sqrt_start = 1'b1;
        cmd.sq_src     = SQ_VAR;
      end
      S_WSQV:  cmd.res_lat = sts.sqrt_done;
      S_FIN:   cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      b_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      b_r     <= b_nxt;
    end
  end

endmodule

>>> sv/spatial_stratum_stdev.sv
// ---------------------------------------------------------------------------
// spatial_stratum_stdev
// standard deviation of a stratum of spatially correlated points, Q16.16
// ---------------------------------------------------------------------------
// loading: points load at one item per cycle; the item flagged last starts
//   the pair pass (one division, two square roots and the exp chain per pair)
//   unless fewer than two points are held, then the final divisions and root
// flow: input stalls from the last item until the result is registered, one stratum at a time
// reset: synchronous, active low; clears counters, handshake and config
//   registers (fitting factor and range 1.0, decay 1); stores are not cleared
module spatial_stratum_stdev (
  input  logic                          clk,
  input  logic                          rst_n,
  // point items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_longitude,
  input  logic signed [31:0]            in_latitude,
  input  logic signed [31:0]            in_target_value,
  input  logic [31:0]                   in_variance,
  input  logic                          in_last_point,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_stratum_stdev,
  output logic [sss_pkg::CNT_W-1:0]     out_points_used,
  output logic                          out_overflow_flag,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import sss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns point count, drop flag and the i/j pair loop
  sss_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_point (in_last_point),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  // stores, shared multiplier, divider and root units, output register
  sss_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_longitude      (in_longitude),
    .in_latitude       (in_latitude),
    .in_target_value   (in_target_value),
    .in_variance       (in_variance),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_stratum_stdev (out_stratum_stdev),
    .out_points_used   (out_points_used),
    .out_overflow_flag (out_overflow_flag)
  );

endmodule

>>> sv/sss_chk.sv
// ---------------------------------------------------------------------------
// sss_chk
// port-level checks of the stratum block, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sss_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      in_last_point,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [31:0]               out_stratum_stdev,
  input logic [sss_pkg::CNT_W-1:0] out_points_used
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_stratum_stdev))

  // an accepted last item closes the input
  `ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && in_last_point, in_stall)

  // a result always covers at least one point
  `ASSERT_IMPL(a_pts_nonzero, out_valid, out_points_used != '0)

  // a new result only comes out of the compute phase
  `ASSERT_IMPL(a_res_after_pass, $rose(out_valid), $past(in_stall))

endmodule

bind spatial_stratum_stdev sss_chk u_chk (.*);
